FILE: rtl/alt_pkg.sv
// shared types, codes and helper functions for the assembly line tokenizer
// no dependencies; imported by every tokenizer module
package alt_pkg;

    // token class codes
    localparam logic [2:0] CLS_REG     = 3'd0;
    localparam logic [2:0] CLS_IMM     = 3'd1;
    localparam logic [2:0] CLS_IDENT   = 3'd2;
    localparam logic [2:0] CLS_COMMA   = 3'd3;
    localparam logic [2:0] CLS_LPAREN  = 3'd4;
    localparam logic [2:0] CLS_RPAREN  = 3'd5;
    localparam logic [2:0] CLS_UNKNOWN = 3'd6;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_R      = 8'd82;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;

    // word length field, wide enough for the largest word capacity
    localparam int LEN_BITS = 6;

    // command from the front part to the back part
    typedef struct packed {
        logic                has_word;
        logic                bank;
        logic [LEN_BITS-1:0] len;
        logic [2:0]          cls;
        logic                trunc;
        logic                sep_valid;
        logic [2:0]          sep_cls;
        logic [7:0]          sep_char;
    } cmd_t;

    // word buffer write port
    typedef struct packed {
        logic                en;
        logic                bank;
        logic [LEN_BITS-1:0] idx;
        logic [7:0]          data;
    } buf_wr_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'd65) && (c <= 8'd90);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if ((c >= 8'd97) && (c <= 8'd122)) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    // class from the first character and whether a digit sits second
    function automatic logic [2:0] word_class(input logic [7:0] c0, input logic second_digit);
        if ((c0 == CH_R) && second_digit) begin
            return CLS_REG;
        end
        if (is_digit(c0) || ((c0 == CH_MINUS) && second_digit)) begin
            return CLS_IMM;
        end
        if (is_upper(c0)) begin
            return CLS_IDENT;
        end
        return CLS_UNKNOWN;
    endfunction

endpackage

FILE: rtl/alt_cmd_fifo.sv
// two-entry command queue between the tokenizer front and back parts
// depends on alt_pkg for the command type
module alt_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  alt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output alt_pkg::cmd_t head_cmd
);
    import alt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/alt_front.sv
// tokenizer front part: accepts characters, builds words in a banked buffer
// and issues flush commands; depends on alt_pkg
module alt_front #(
    parameter int WORD_CAPACITY = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_char,
    output alt_pkg::buf_wr_t buf_wr,
    output logic            cmd_push,
    output alt_pkg::cmd_t   cmd,
    input  logic            cmd_full,
    input  logic            bank_release,
    input  logic            release_bank
);
    import alt_pkg::*;

    localparam int LEN_W = $clog2(WORD_CAPACITY + 1);

    logic [LEN_W-1:0] len_reg;
    logic             ovf_reg;
    logic [7:0]       c0_reg;
    logic             d1_reg;
    logic             bank_reg;
    logic [1:0]       busy_reg;

    logic       accept;
    logic       space_ch;
    logic       sep_ch;
    logic       has_word;
    logic       flush;
    logic [7:0] up_ch;
    logic       room;

    assign in_ready = !cmd_full && !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;
    assign space_ch = is_space(in_char);
    assign sep_ch   = (in_char == CH_COMMA) || (in_char == CH_LPAREN)
                   || (in_char == CH_RPAREN);
    assign has_word = (len_reg != '0);
    assign flush    = accept && (space_ch || sep_ch) && has_word;
    assign up_ch    = to_upper(in_char);
    assign room     = (len_reg < LEN_W'(WORD_CAPACITY));

    // word buffer write
    always_comb begin
        buf_wr.en   = accept && !space_ch && !sep_ch && room;
        buf_wr.bank = bank_reg;
        buf_wr.idx  = LEN_BITS'(len_reg);
        buf_wr.data = up_ch;
    end

    // command build
    always_comb begin
        cmd.has_word  = has_word;
        cmd.bank      = bank_reg;
        cmd.len       = LEN_BITS'(len_reg);
        cmd.cls       = word_class(c0_reg, d1_reg && (len_reg >= LEN_W'(2)));
        cmd.trunc     = ovf_reg;
        cmd.sep_valid = sep_ch;
        if (in_char == CH_COMMA) begin
            cmd.sep_cls = CLS_COMMA;
        end else if (in_char == CH_LPAREN) begin
            cmd.sep_cls = CLS_LPAREN;
        end else begin
            cmd.sep_cls = CLS_RPAREN;
        end
        cmd.sep_char = in_char;
        cmd_push     = accept && (sep_ch || (space_ch && has_word));
    end

    // first-character and second-digit capture
    always_ff @(posedge aclk) begin
        if (buf_wr.en && (len_reg == '0)) begin
            c0_reg <= up_ch;
        end
        if (buf_wr.en && (len_reg == LEN_W'(1))) begin
            d1_reg <= is_digit(up_ch);
        end
    end

    // word length, overflow and bank ownership
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end else begin
            if (bank_release) begin
                busy_reg[release_bank] <= 1'b0;
            end
            if (flush) begin
                busy_reg[bank_reg] <= 1'b1;
                bank_reg           <= ~bank_reg;
                len_reg            <= '0;
                ovf_reg            <= 1'b0;
            end else if (accept && !space_ch && !sep_ch) begin
                if (room) begin
                    len_reg <= len_reg + LEN_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/alt_back.sv
// tokenizer back part: word buffer memory, output register and playout of flush
// commands, one result per cycle unless stalled; depends on alt_pkg
module alt_back #(
    parameter int WORD_CAPACITY = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  alt_pkg::buf_wr_t buf_wr,
    input  logic             head_valid,
    input  alt_pkg::cmd_t    head_cmd,
    output logic             pop,
    output logic             bank_release,
    output logic             release_bank,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_cls,
    output logic [7:0]       out_char,
    output logic [4:0]       out_pos,
    output logic             out_token_end,
    output logic             out_trunc,
    output logic             out_run_end
);
    import alt_pkg::*;

    localparam int AW    = $clog2(WORD_CAPACITY);
    localparam int LEN_W = $clog2(WORD_CAPACITY + 1);
    localparam int DEPTH = 2 * (2 ** AW);

    localparam logic PH_WORD = 1'b0;
    localparam logic PH_SEP  = 1'b1;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    logic             phase_reg;
    logic [LEN_W-1:0] idx_reg;

    // read stage
    logic       rd_valid_reg;
    logic [2:0] rd_cls_reg;
    logic [4:0] rd_pos_reg;
    logic       rd_end_reg;
    logic       rd_trunc_reg;
    logic       rd_run_end_reg;
    logic       rd_is_sep_reg;
    logic [7:0] rd_sep_char_reg;

    // output register
    logic       out_valid_reg;
    logic [2:0] out_cls_reg;
    logic [7:0] out_char_reg;
    logic [4:0] out_pos_reg;
    logic       out_end_reg;
    logic       out_trunc_reg;
    logic       out_run_end_reg;

    logic out_load;
    logic issue;
    logic word_step;
    logic last_ch;

    assign out_load  = !out_valid_reg || out_ready;
    assign issue     = head_valid && (!rd_valid_reg || out_load);
    assign word_step = head_cmd.has_word && (phase_reg == PH_WORD);
    assign last_ch   = (LEN_BITS'(idx_reg) == (head_cmd.len - LEN_BITS'(1)));

    assign pop          = issue && (!word_step || (last_ch && !head_cmd.sep_valid));
    assign bank_release = issue && word_step && last_ch;
    assign release_bank = head_cmd.bank;

    // word buffer memory
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[{buf_wr.bank, buf_wr.idx[AW-1:0]}] <= buf_wr.data;
        end
        if (issue) begin
            rdata_reg <= mem[{head_cmd.bank, idx_reg[AW-1:0]}];
        end
    end

    // playout sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WORD;
            idx_reg   <= '0;
        end else if (issue) begin
            if (word_step) begin
                if (last_ch) begin
                    idx_reg <= '0;
                    if (head_cmd.sep_valid) begin
                        phase_reg <= PH_SEP;
                    end
                end else begin
                    idx_reg <= idx_reg + LEN_W'(1);
                end
            end else begin
                phase_reg <= PH_WORD;
            end
        end
    end

    // read stage metadata
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (issue) begin
            rd_valid_reg <= 1'b1;
        end else if (out_load) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_is_sep_reg   <= !word_step;
            rd_sep_char_reg <= head_cmd.sep_char;
            if (word_step) begin
                rd_cls_reg     <= head_cmd.cls;
                rd_pos_reg     <= 5'(idx_reg);
                rd_end_reg     <= last_ch;
                rd_trunc_reg   <= head_cmd.trunc;
                rd_run_end_reg <= last_ch && !head_cmd.sep_valid;
            end else begin
                rd_cls_reg     <= head_cmd.sep_cls;
                rd_pos_reg     <= 5'd0;
                rd_end_reg     <= 1'b1;
                rd_trunc_reg   <= 1'b0;
                rd_run_end_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && rd_valid_reg) begin
            out_cls_reg     <= rd_cls_reg;
            out_char_reg    <= rd_is_sep_reg ? rd_sep_char_reg : rdata_reg;
            out_pos_reg     <= rd_pos_reg;
            out_end_reg     <= rd_end_reg;
            out_trunc_reg   <= rd_trunc_reg;
            out_run_end_reg <= rd_run_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cls       = out_cls_reg;
    assign out_char      = out_char_reg;
    assign out_pos       = out_pos_reg;
    assign out_token_end = out_end_reg;
    assign out_trunc     = out_trunc_reg;
    assign out_run_end   = out_run_end_reg;

endmodule

FILE: rtl/assembly_line_tokenizer_core.sv
// top level of the assembly line tokenizer: front part, command queue, back part
// depends on alt_pkg, alt_front, alt_cmd_fifo and alt_back
//
// usage:
//   s_ channel carries one character per transaction (s_tdata[7:0]); code 0
//   ends the line. whitespace, comma, parentheses and line end close the
//   current word. m_ channel carries one token character per transaction,
//   class in m_tuser; m_tlast marks the last result caused by one input.
//   word characters are accepted one per cycle and produce no result.
//   a closing character with a word of N stored characters produces N
//   results (plus one for a separator); the first passes through the
//   command queue, the read stage and the output register. throughput is
//   set by the playout sequencer, one result per cycle while m_tready is
//   high, and by two word buffer banks: the front stalls s_tready once
//   both banks hold unplayed words, or the two-entry command queue is full.
//   reset clears word length, overflow flag, queue and output register; the
//   buffer memory needs no clearing. when m_tready is low the output register
//   holds and back pressure reaches s_tready through the queue and banks.
module assembly_line_tokenizer_core #(
    parameter int WORD_CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] token_char, [12:8] char_position,
                                   // [13] token_end, [14] truncated, [15] zero
    output logic [2:0]  m_tuser,   // [2:0] token_class
    output logic        m_tlast
);
    import alt_pkg::*;

    buf_wr_t    buf_wr;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       cmd_push;
    logic       cmd_full;
    logic       head_valid;
    logic       pop;
    logic       bank_release;
    logic       release_bank;
    logic [7:0] token_char;
    logic [4:0] char_position;
    logic       token_end;
    logic       truncated;

    alt_front #(
        .WORD_CAPACITY(WORD_CAPACITY)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_char      (s_tdata),
        .buf_wr       (buf_wr),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd),
        .cmd_full     (cmd_full),
        .bank_release (bank_release),
        .release_bank (release_bank)
    );

    alt_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .full       (cmd_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    alt_back #(
        .WORD_CAPACITY(WORD_CAPACITY)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .buf_wr        (buf_wr),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .bank_release  (bank_release),
        .release_bank  (release_bank),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_cls       (m_tuser),
        .out_char      (token_char),
        .out_pos       (char_position),
        .out_token_end (token_end),
        .out_trunc     (truncated),
        .out_run_end   (m_tlast)
    );

    // result packing
    assign m_tdata = {1'b0, truncated, token_end, char_position, token_char};

    // separator tokens end a token at position 0 and are never marked truncated
    a_sep_not_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == CLS_COMMA) || (m_tuser == CLS_LPAREN)
            || (m_tuser == CLS_RPAREN)) |-> !truncated && token_end
            && (char_position == 5'd0))
        else $error("separator token with bad flags");

    // the last result of a run always closes a token
    a_run_end_token_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> token_end)
        else $error("run end without token end");

    // the queue is never pushed while full
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_full |-> !cmd_push)
        else $error("command pushed into a full queue");

    // a bank is released only while a command is being played out
    a_release_with_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_release |-> head_valid && head_cmd.has_word)
        else $error("bank release without a word command");

endmodule

FILE: test/assembly_line_tokenizer_core_test.sv
// self-checking bench for assembly_line_tokenizer_core: directed rows, then random lines
// depends on alt_pkg and the tokenizer rtl; holds its own character-level token predictor
module assembly_line_tokenizer_core_test;
    import alt_pkg::*;

    localparam int WORD_CAPACITY = 32;
    localparam int PHASE_ITEMS   = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 40;

    // one token character as it leaves the block
    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] token_char;
        logic [4:0] char_position;
        logic       token_end;
        logic       truncated;
        logic       run_end;
    } token_t;

    // directed stimulus row; typed rows carry their single result
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        token_t     want;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [7:0] word_chars [WORD_CAPACITY];
    int         word_len      = 0;
    bit         word_overflow = 1'b0;

    token_t     pending_tokens [$];
    logic [7:0] line_chars [$];
    row_t       directed_rows [$];

    int   tx_idle_pct     = 0;
    int   rx_idle_pct     = 0;
    logic hold_stretch    = 1'b0;
    int   hold_cnt        = 0;
    int   idle_cycles     = 0;
    int   error_count     = 0;
    int   chars_sent      = 0;
    int   lines_sent      = 0;
    int   results_checked = 0;
    int   trunc_words     = 0;

    assembly_line_tokenizer_core #(
        .WORD_CAPACITY(WORD_CAPACITY)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // class of the buffered word from its first two characters
    function automatic logic [2:0] classify_word();
        logic [7:0] first;
        bit         digit_second;
        first        = word_chars[0];
        digit_second = (word_len >= 2) && (word_chars[1] >= "0") && (word_chars[1] <= "9");
        if ((first == CH_R) && digit_second) begin
            return CLS_REG;
        end
        if (((first >= "0") && (first <= "9")) || ((first == CH_MINUS) && digit_second)) begin
            return CLS_IMM;
        end
        if ((first >= "A") && (first <= "Z")) begin
            return CLS_IDENT;
        end
        return CLS_UNKNOWN;
    endfunction

    // advance the predictor by one character and list the token characters it releases
    function automatic void tokenize_char(input logic [7:0] c, output token_t res[$]);
        logic [7:0] up;
        logic [2:0] cls;
        bit         closes_word;
        bit         is_sep;
        res.delete();
        is_sep      = (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN);
        closes_word = is_sep || (c == CH_NUL) || (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
        if (closes_word) begin
            // flush the pending word, one result per stored character
            if (word_len > 0) begin
                cls = classify_word();
                for (int i = 0; i < word_len; i++) begin
                    res.push_back('{cls, word_chars[i], 5'(i), (i == word_len - 1),
                                    word_overflow, 1'b0});
                end
            end
            word_len      = 0;
            word_overflow = 1'b0;
            if (is_sep) begin
                cls = (c == CH_COMMA) ? CLS_COMMA : (c == CH_LPAREN) ? CLS_LPAREN : CLS_RPAREN;
                res.push_back('{cls, c, 5'd0, 1'b1, 1'b0, 1'b0});
            end
            if (res.size() > 0) begin
                res[res.size() - 1].run_end = 1'b1;
            end
        end else begin
            // word character: only a..z change case; a full buffer drops it
            up = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
            if (word_len < WORD_CAPACITY) begin
                word_chars[word_len] = up;
                word_len++;
            end else begin
                word_overflow = 1'b1;
            end
        end
    endfunction

    function automatic row_t plain_row(input logic [7:0] c);
        row_t r;
        r.ch    = c;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // separator with no word in front: one token with fixed fields
    function automatic row_t sep_row(input logic [7:0] c, input logic [2:0] cls);
        row_t r;
        r.ch    = c;
        r.typed = 1'b1;
        r.want  = '{cls, c, 5'd0, 1'b1, 1'b0, 1'b1};
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= 40) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "A" : "a");
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(0, 9)) + "0";
    endfunction

    // append one random line of words and separators; long_len forces a long first word
    task automatic queue_line(input int long_len);
        int         n_words;
        int         len;
        int         kind;
        logic [7:0] c;
        n_words = $urandom_range(1, 4);
        for (int w = 0; w < n_words; w++) begin
            kind = $urandom_range(0, 4);
            len  = $urandom_range(1, 6);
            if ((w == 0) && (long_len > 0)) begin
                kind = 2;
                len  = long_len;
            end
            for (int i = 0; i < len; i++) begin
                case (kind)
                    0: begin
                        c = (i == 0) ? ($urandom_range(0, 1) ? CH_R : "r") : rand_digit();
                    end
                    1: begin
                        c = ((i == 0) && $urandom_range(0, 1)) ? CH_MINUS : rand_digit();
                    end
                    2: begin
                        c = ((i == 0) || $urandom_range(0, 2)) ? rand_letter() : rand_digit();
                    end
                    default: begin
                        c = 8'($urandom_range(0, 255));
                    end
                endcase
                // occasional noise byte inside a word
                if ($urandom_range(0, 99) < 8) begin
                    c = 8'($urandom_range(0, 255));
                end
                line_chars.push_back(c);
            end
            case ($urandom_range(0, 5))
                0, 1: begin
                    line_chars.push_back(CH_SPACE);
                end
                2: begin
                    line_chars.push_back(CH_COMMA);
                end
                3: begin
                    line_chars.push_back(CH_LPAREN);
                end
                4: begin
                    line_chars.push_back(CH_RPAREN);
                end
                default: begin
                    line_chars.push_back(8'($urandom_range(9, 13)));
                end
            endcase
        end
        line_chars.push_back(CH_NUL);
    endtask

    // offer one character, wait for the transaction, return its predicted tokens
    task automatic send_char(input logic [7:0] c, output token_t res[$]);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        tokenize_char(c, res);
        chars_sent++;
        if (c == CH_NUL) begin
            lines_sent++;
        end
    endtask

    // sender goes quiet until every predicted token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_tokens.size() != 0);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int long_len,
                             input bit hold);
        token_t res[$];
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold) begin
            hold_stretch <= 1'b1;
        end
        line_chars.delete();
        queue_line(long_len);
        while (line_chars.size() < PHASE_ITEMS) begin
            queue_line(0);
        end
        foreach (line_chars[i]) begin
            send_char(line_chars[i], res);
            foreach (res[k]) begin
                pending_tokens.push_back(res[k]);
            end
        end
        drain();
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_stretch && (hold_cnt < HOLD_CYCLES)) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result checking against the oldest predicted token
    always @(posedge aclk) begin : result_check
        token_t got;
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[13], m_tdata[14], m_tlast};
            results_checked++;
            if (got.truncated && got.token_end) begin
                trunc_words++;
            end
            if (pending_tokens.size() == 0) begin
                error_count++;
                if (error_count <= 40) begin
                    $error("unexpected result transaction: char %0d class %0d",
                           got.token_char, got.token_class);
                end
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_class", want.token_class, got.token_class);
                check_field("token_char", want.token_char, got.token_char);
                check_field("char_position", want.char_position, got.char_position);
                check_field("token_end", want.token_end, got.token_end);
                check_field("truncated", want.truncated, got.truncated);
                check_field("run_end", want.run_end, got.run_end);
                check_field("tdata_pad", 0, m_tdata[15]);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d tokens still expected", pending_tokens.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        token_t res[$];
        foreach (word_chars[i]) begin
            word_chars[i] = 8'd0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: lone separators, empty line ends, every word class, odd bytes
        directed_rows.push_back(sep_row(CH_COMMA, CLS_COMMA));
        directed_rows.push_back(sep_row(CH_LPAREN, CLS_LPAREN));
        directed_rows.push_back(sep_row(CH_RPAREN, CLS_RPAREN));
        directed_rows.push_back(plain_row(CH_NUL));
        directed_rows.push_back(plain_row(CH_SPACE));
        directed_rows.push_back(plain_row("r"));
        directed_rows.push_back(plain_row("5"));
        directed_rows.push_back(plain_row(CH_COMMA));
        directed_rows.push_back(plain_row(CH_MINUS));
        directed_rows.push_back(plain_row("7"));
        directed_rows.push_back(plain_row(8'd9));
        directed_rows.push_back(plain_row("a"));
        directed_rows.push_back(plain_row("z"));
        directed_rows.push_back(plain_row(8'd13));
        directed_rows.push_back(plain_row(8'hFF));
        directed_rows.push_back(plain_row(8'h80));
        directed_rows.push_back(plain_row(8'h01));
        directed_rows.push_back(plain_row(CH_NUL));
        directed_rows.push_back(plain_row(CH_MINUS));
        directed_rows.push_back(plain_row("x"));
        directed_rows.push_back(plain_row(CH_RPAREN));
        directed_rows.push_back(plain_row("9"));
        directed_rows.push_back(plain_row(8'd10));
        directed_rows.push_back(plain_row(CH_R));
        directed_rows.push_back(plain_row(8'd11));

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].ch, res);
            if (directed_rows[i].typed) begin
                pending_tokens.push_back(directed_rows[i].want);
            end else begin
                foreach (res[k]) begin
                    pending_tokens.push_back(res[k]);
                end
            end
        end
        drain();

        // random lines: full-buffer word, overflowing word, then any long word
        run_phase(15, 59, WORD_CAPACITY, 1'b0);
        run_phase(59, 15, WORD_CAPACITY + 1 + $urandom_range(0, 7), 1'b0);
        run_phase(0, 0, $urandom_range(28, 40), 1'b1);

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d characters in %0d lines; %0d token characters checked",
                 chars_sent, lines_sent, results_checked);
        $display("words that lost characters: %0d; receiver held off once for %0d cycles",
                 trunc_words, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/alt_pkg.sv
rtl/alt_cmd_fifo.sv
rtl/alt_front.sv
rtl/alt_back.sv
rtl/assembly_line_tokenizer_core.sv
test/assembly_line_tokenizer_core_test.sv
